// ===== hw/rtl/swr_pkg.sv =====
// swr_pkg: types, widths and codes of the systematic weight resampler
// used by every module of the block; depends on nothing
package swr_pkg;

  localparam int unsigned MaxParticles = 64;
  localparam int unsigned MaxDims      = 4;
  localparam int unsigned IdxW         = $clog2(MaxParticles);
  localparam int unsigned CntW         = IdxW + 1;
  localparam int unsigned WeightW      = 16;
  localparam int unsigned WordW        = 32;
  localparam int unsigned PrefixW      = 22;
  localparam int unsigned TwoNW        = CntW + 1;
  localparam int unsigned TargetW      = PrefixW + TwoNW - 1;
  localparam int unsigned DimsW        = 3;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = CntW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PARTICLE_COUNT = 2'd0,
    CFG_DIMS_IN_USE    = 2'd1
  } swr_cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_CMP  = 5'b01000,
    ST_EMIT = 5'b10000
  } swr_state_e;

  typedef struct packed {
    logic        [WeightW-1:0] weight;
    logic signed [WordW-1:0]   state_a;
    logic signed [WordW-1:0]   state_b;
    logic signed [WordW-1:0]   state_c;
    logic signed [WordW-1:0]   state_d;
  } swr_in_t;

  typedef struct packed {
    logic        [IdxW-1:0]  source_index;
    logic                    found;
    logic                    sum_too_small;
    logic signed [WordW-1:0] out_a;
    logic signed [WordW-1:0] out_b;
    logic signed [WordW-1:0] out_c;
    logic signed [WordW-1:0] out_d;
    logic                    last_slot;
  } swr_out_t;

  typedef logic [MaxDims-1:0][WordW-1:0] swr_row_t;

  typedef struct packed {
    logic               we;
    logic [IdxW-1:0]    waddr;
    logic [PrefixW-1:0] prefix;
    swr_row_t           row;
    logic [IdxW-1:0]    raddr;
  } swr_mem_req_t;

endpackage

// ===== hw/rtl/systematic_weight_resampler.sv =====
// systematic_weight_resampler: top level, load path, walk sequencer and output register
// depends on swr_pkg, swr_store, swr_mac
//
// usage: particles come in on the input channel, one beat per particle, one per
// cycle while in_ready_o is high. the beat that completes a round of N particles
// (N from particle_count, clamped to 2..64) starts the emission of N result beats.
// during the emission in_ready_o is low. each slot target is compared against the
// prefix sums by one shared multiply and compare unit; the walk moves forward over
// the particles with a memory read, a scale and a compare per particle visited,
// then loads the output register once per slot, with one more compare for each
// slot after the first. a zero weight total emits N slots with found cleared.
// the output register holds a beat until out_ready_i takes it; a stall simply
// holds the walk. the last beat of a round may still wait while the next round
// loads. reset clears the counters, the registers go to particle_count 64 and
// dims_in_use 4, and no output beat is pending. configuration writes land at once.
module systematic_weight_resampler import swr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  swr_in_t             in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output swr_out_t            out_data_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  swr_state_e         state_q, state_d;
  logic [CntW-1:0]    pcount_q, pcount_d;
  logic [DimsW-1:0]   dims_cfg_q, dims_cfg_d;
  logic [CntW-1:0]    load_count_q, load_count_d;
  logic [PrefixW-1:0] total_q, total_d;
  logic [CntW-1:0]    n_q, n_d;
  logic [DimsW-1:0]   dims_q, dims_d;
  logic [PrefixW-1:0] rtotal_q, rtotal_d;
  logic [TargetW-1:0] target_q, target_d;
  logic [IdxW-1:0]    k_q, k_d;
  logic [IdxW-1:0]    slot_q, slot_d;
  logic               out_valid_q, out_valid_d;
  swr_out_t           out_q, out_d;

  logic [CntW-1:0]    n_eff;
  logic [DimsW-1:0]   dims_eff;
  logic               restart;
  logic [CntW-1:0]    idx;
  logic [PrefixW-1:0] new_total;
  logic               round_done;
  logic               out_free;
  logic               last;
  logic               found;
  logic               ge;
  logic [PrefixW-1:0] prefix_rd;
  swr_row_t           row_rd;
  swr_mem_req_t       mem_req;
  swr_out_t           slot_beat;

  assign n_eff = (pcount_q < CntW'(2)) ? CntW'(2) :
                 (pcount_q > CntW'(MaxParticles)) ? CntW'(MaxParticles) : pcount_q;
  assign dims_eff = (dims_cfg_q < DimsW'(1)) ? DimsW'(1) :
                    (dims_cfg_q > DimsW'(MaxDims)) ? DimsW'(MaxDims) : dims_cfg_q;

  assign in_ready_o = (state_q == ST_IDLE);
  assign restart    = load_count_q >= n_eff;
  assign idx        = restart ? '0 : load_count_q;
  assign new_total  = (restart ? '0 : total_q) + PrefixW'(in_data_i.weight);
  assign round_done = (idx + CntW'(1)) == n_eff;
  assign out_free   = !out_valid_q || out_ready_i;
  assign last       = ({1'b0, slot_q} + CntW'(1)) == n_q;
  assign found      = rtotal_q != '0;

  always_comb begin
    mem_req.we     = in_valid_i && in_ready_o;
    mem_req.waddr  = idx[IdxW-1:0];
    mem_req.prefix = new_total;
    mem_req.row    = {in_data_i.state_d, in_data_i.state_c,
                      in_data_i.state_b, in_data_i.state_a};
    mem_req.raddr  = k_q;
  end

  swr_store u_store (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .prefix_o (prefix_rd),
    .row_o    (row_rd)
  );

  swr_mac u_mac (
    .clk_i    (clk_i),
    .load_i   (state_q == ST_MUL),
    .prefix_i (prefix_rd),
    .two_n_i  ({n_q, 1'b0}),
    .target_i (target_q),
    .ge_o     (ge)
  );

  always_comb begin
    slot_beat.source_index  = found ? k_q : '0;
    slot_beat.found         = found;
    slot_beat.sum_too_small = !found;
    slot_beat.out_a         = (found && dims_q > DimsW'(0)) ? row_rd[0] : '0;
    slot_beat.out_b         = (found && dims_q > DimsW'(1)) ? row_rd[1] : '0;
    slot_beat.out_c         = (found && dims_q > DimsW'(2)) ? row_rd[2] : '0;
    slot_beat.out_d         = (found && dims_q > DimsW'(3)) ? row_rd[3] : '0;
    slot_beat.last_slot     = last;
  end

  always_comb begin
    pcount_d   = pcount_q;
    dims_cfg_d = dims_cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PARTICLE_COUNT: pcount_d   = cfg_data_i;
        CFG_DIMS_IN_USE:    dims_cfg_d = cfg_data_i[DimsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    load_count_d = load_count_q;
    total_d      = total_q;
    n_d          = n_q;
    dims_d       = dims_q;
    rtotal_d     = rtotal_q;
    target_d     = target_q;
    k_d          = k_q;
    slot_d       = slot_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (round_done) begin
            load_count_d = '0;
            total_d      = '0;
            n_d          = n_eff;
            dims_d       = dims_eff;
            rtotal_d     = new_total;
            target_d     = TargetW'(new_total);
            k_d          = '0;
            slot_d       = '0;
            state_d      = (new_total == '0) ? ST_EMIT : ST_RD;
          end else begin
            load_count_d = idx + CntW'(1);
            total_d      = new_total;
          end
        end
      end
      ST_RD:  state_d = ST_MUL;
      ST_MUL: state_d = ST_CMP;
      ST_CMP: begin
        if (ge) begin
          state_d = ST_EMIT;
        end else begin
          k_d     = k_q + IdxW'(1);
          state_d = ST_RD;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_d       = slot_beat;
          out_valid_d = 1'b1;
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            slot_d   = slot_q + IdxW'(1);
            target_d = target_q + TargetW'({rtotal_q, 1'b0});
            state_d  = found ? ST_CMP : ST_EMIT;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pcount_q     <= CntW'(MaxParticles);
      dims_cfg_q   <= DimsW'(MaxDims);
      load_count_q <= '0;
      total_q      <= '0;
      n_q          <= CntW'(2);
      slot_q       <= '0;
      k_q          <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pcount_q     <= pcount_d;
      dims_cfg_q   <= dims_cfg_d;
      load_count_q <= load_count_d;
      total_q      <= total_d;
      n_q          <= n_d;
      slot_q       <= slot_d;
      k_q          <= k_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dims_q   <= dims_d;
    rtotal_q <= rtotal_d;
    target_q <= target_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // walk and slot counters stay inside the loaded round
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> ({1'b0, k_q} < n_q && {1'b0, slot_q} < n_q))
    else $error("walk index or slot past the round");

  // a miss can never happen on the last particle, its prefix is the total
  a_last_particle_hits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP && ({1'b0, k_q} + CntW'(1)) == n_q) |-> ge)
    else $error("no particle chosen for a slot");

  // found and sum_too_small are exclusive on every beat
  a_found_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.found != out_data_o.sum_too_small))
    else $error("found and sum_too_small disagree");

  // the output register is only overwritten once its beat is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> $stable(out_q))
    else $error("pending beat overwritten");

endmodule

// ===== hw/rtl/swr_store.sv =====
// swr_store: prefix sum memory and particle state memory, one row per particle
// depends on swr_pkg
module swr_store import swr_pkg::*; (
  input  logic               clk_i,
  input  swr_mem_req_t       req_i,
  output logic [PrefixW-1:0] prefix_o,
  output swr_row_t           row_o
);

  logic [PrefixW-1:0] prefix_mem [MaxParticles];
  swr_row_t           row_mem    [MaxParticles];
  logic [PrefixW-1:0] prefix_q;
  swr_row_t           row_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      prefix_mem[req_i.waddr] <= req_i.prefix;
      row_mem[req_i.waddr]    <= req_i.row;
    end
    prefix_q <= prefix_mem[req_i.raddr];
    row_q    <= row_mem[req_i.raddr];
  end

  assign prefix_o = prefix_q;
  assign row_o    = row_q;

endmodule

// ===== hw/rtl/swr_mac.sv =====
// swr_mac: shared scale and compare unit, prefix times 2N against the slot target
// depends on swr_pkg
module swr_mac import swr_pkg::*; (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic [PrefixW-1:0] prefix_i,
  input  logic [TwoNW-1:0]   two_n_i,
  input  logic [TargetW-1:0] target_i,
  output logic               ge_o
);

  logic [TargetW-1:0] product_q;
  logic [TargetW-1:0] product_d;

  assign product_d = TargetW'(prefix_i * two_n_i);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      product_q <= product_d;
    end
  end

  assign ge_o = product_q >= target_i;

endmodule

// ===== tb/systematic_weight_resampler_tb.sv =====
// systematic_weight_resampler_tb: self-checking bench for the systematic weight resampler
// predicts every resampled beat and checks it field by field; depends on swr_pkg and the rtl
`timescale 1ns / 100ps

module systematic_weight_resampler_tb;
  import swr_pkg::*;

  localparam int unsigned SettleCycles = 4 * MaxParticles + 32;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_B = 2'd3;
  localparam int unsigned RandomItems = 260;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  swr_in_t             in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  swr_out_t            out_data_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = CFG_PARTICLE_COUNT;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  systematic_weight_resampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  swr_in_t  particle_q[$];
  swr_out_t resampled_q[$];
  int unsigned mismatch_cnt = 0;

  // predictor state
  logic [WeightW-1:0] wt_mem   [MaxParticles];
  logic [PrefixW-1:0] psum_mem [MaxParticles];
  logic [WordW-1:0]   word_mem [MaxParticles][MaxDims];
  logic [CntW-1:0]    load_cnt = '0;
  logic [PrefixW-1:0] wsum = '0;
  logic [CntW-1:0]    count_reg = CntW'(MaxParticles);
  logic [DimsW-1:0]   dims_reg = DimsW'(MaxDims);

  bit          in_taken = 1'b0;
  bit          steady_send = 1'b0;
  bit          steady_recv = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned open_left = 0;
  int unsigned stall_left = 0;

  task automatic load_particle(input swr_in_t beat);
    int unsigned n, dims, idx, j, k, src;
    longint unsigned two_n, total, target, after, before_sum;
    bit hit;
    swr_out_t r;
    n = count_reg;
    if (n < 2) n = 2;
    if (n > MaxParticles) n = MaxParticles;
    dims = dims_reg;
    if (dims < 1) dims = 1;
    if (dims > MaxDims) dims = MaxDims;
    if (load_cnt >= n) begin
      load_cnt = '0;
      wsum = '0;
    end
    idx = load_cnt[IdxW-1:0];
    wt_mem[idx] = beat.weight;
    wsum = wsum + PrefixW'(beat.weight);
    psum_mem[idx] = wsum;
    word_mem[idx][0] = beat.state_a;
    word_mem[idx][1] = beat.state_b;
    word_mem[idx][2] = beat.state_c;
    word_mem[idx][3] = beat.state_d;
    load_cnt = load_cnt + 1'b1;
    if (load_cnt < n) return;
    two_n = 2 * n;
    total = wsum;
    for (j = 0; j < n; j++) begin
      target = (2 * longint'(j) + 1) * total;
      hit = 1'b0;
      src = 0;
      if (total != 0) begin
        for (k = 0; k < n && !hit; k++) begin
          after = psum_mem[k];
          before_sum = after - wt_mem[k];
          if (before_sum * two_n < target && target <= after * two_n) begin
            hit = 1'b1;
            src = k;
          end
        end
      end
      r.source_index  = hit ? IdxW'(src) : '0;
      r.found         = hit;
      r.sum_too_small = (total == 0);
      r.out_a         = hit ? word_mem[src][0] : '0;
      r.out_b         = (hit && dims > 1) ? word_mem[src][1] : '0;
      r.out_c         = (hit && dims > 2) ? word_mem[src][2] : '0;
      r.out_d         = (hit && dims > 3) ? word_mem[src][3] : '0;
      r.last_slot     = (j + 1 == n);
      resampled_q.push_back(r);
    end
    load_cnt = '0;
    wsum = '0;
  endtask

  // accepted beats on both channels
  always @(posedge clk_i) begin
    swr_out_t exp_beat;
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (in_taken) load_particle(in_data_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (resampled_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected beat: idx=%0d found=%b a=%h", out_data_o.source_index,
                   out_data_o.found, out_data_o.out_a);
      end else begin
        exp_beat = resampled_q.pop_front();
        if (out_data_o.source_index !== exp_beat.source_index ||
            out_data_o.found !== exp_beat.found ||
            out_data_o.sum_too_small !== exp_beat.sum_too_small ||
            out_data_o.out_a !== exp_beat.out_a || out_data_o.out_b !== exp_beat.out_b ||
            out_data_o.out_c !== exp_beat.out_c || out_data_o.out_d !== exp_beat.out_d ||
            out_data_o.last_slot !== exp_beat.last_slot) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("mismatch exp: idx=%0d found=%b small=%b a=%h b=%h c=%h d=%h last=%b",
                     exp_beat.source_index, exp_beat.found, exp_beat.sum_too_small,
                     exp_beat.out_a, exp_beat.out_b, exp_beat.out_c, exp_beat.out_d,
                     exp_beat.last_slot);
            $display("         got: idx=%0d found=%b small=%b a=%h b=%h c=%h d=%h last=%b",
                     out_data_o.source_index, out_data_o.found, out_data_o.sum_too_small,
                     out_data_o.out_a, out_data_o.out_b, out_data_o.out_c, out_data_o.out_d,
                     out_data_o.last_slot);
          end
        end
      end
    end
  end

  // sender: bursts with gaps
  always @(negedge clk_i) begin
    if (in_valid_i && !in_taken) begin
    end else if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      gap_left--;
    end else if (particle_q.size() != 0) begin
      in_data_i  <= particle_q.pop_front();
      in_valid_i <= 1'b1;
      if (!steady_send) begin
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = $urandom_range(1, 6);
        end
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // receiver: open runs and stalls
  always @(negedge clk_i) begin
    if (steady_recv) begin
      out_ready_i <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (open_left > 0) begin
      out_ready_i <= 1'b1;
      open_left--;
    end else begin
      open_left = $urandom_range(0, 10);
      stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 25) : $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end
  end

  function automatic logic [WordW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WeightW-1:0] rand_weight(input int unsigned style);
    case (style)
      1: return WeightW'($urandom_range(0, 3));
      2: return ($urandom_range(0, 3) == 0) ? WeightW'($urandom) : '0;
      3: return ($urandom_range(0, 1) == 0) ? 16'hffff : 16'h0000;
      4: return '0;
      default: return WeightW'($urandom);
    endcase
  endfunction

  task automatic queue_round(input int unsigned cnt, input int unsigned style);
    swr_in_t p;
    for (int unsigned i = 0; i < cnt; i++) begin
      p.weight  = rand_weight(style);
      p.state_a = rand_word();
      p.state_b = rand_word();
      p.state_c = rand_word();
      p.state_d = rand_word();
      particle_q.push_back(p);
    end
  endtask

  task automatic drain();
    while (particle_q.size() != 0 || in_valid_i || resampled_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PARTICLE_COUNT) count_reg = val;
    else if (idx == CFG_DIMS_IN_USE) dims_reg = val[DimsW-1:0];
  endtask

  initial begin
    int unsigned sent, cnt_val, n_eff, rounds, extra, sel;
    logic [CfgDataW-1:0] dims_val;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, zero total, clamped registers, dropped round, spare indexes
    write_reg(CFG_PARTICLE_COUNT, 7'd2);
    write_reg(CFG_DIMS_IN_USE, 7'd4);
    particle_q.push_back(swr_in_t'{16'hffff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0});
    particle_q.push_back(swr_in_t'{16'h0000, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff});
    queue_round(2, 4);
    drain();
    write_reg(CFG_PARTICLE_COUNT, 7'd0);
    write_reg(CFG_DIMS_IN_USE, 7'd0);
    particle_q.push_back(swr_in_t'{16'h0001, 32'h1234_5678, 32'h1, 32'h2, 32'h3});
    particle_q.push_back(swr_in_t'{16'hffff, 32'hdead_beef, 32'h4, 32'h5, 32'h6});
    drain();
    write_reg(CFG_PARTICLE_COUNT, 7'd1);
    write_reg(CFG_DIMS_IN_USE, 7'd7);
    queue_round(2, 3);
    drain();
    write_reg(CFG_PARTICLE_COUNT, 7'd3);
    write_reg(CFG_DIMS_IN_USE, 7'd5);
    particle_q.push_back(swr_in_t'{16'h8000, 32'h1, 32'h2, 32'h3, 32'h4});
    particle_q.push_back(swr_in_t'{16'h0000, 32'h5, 32'h6, 32'h7, 32'h8});
    particle_q.push_back(swr_in_t'{16'h8000, 32'h9, 32'ha, 32'hb, 32'hc});
    drain();
    write_reg(CFG_PARTICLE_COUNT, 7'd4);
    write_reg(CFG_DIMS_IN_USE, 7'd2);
    queue_round(3, 0);
    drain();
    write_reg(CFG_PARTICLE_COUNT, 7'd2);
    queue_round(2, 0);
    drain();
    write_reg(CFG_SPARE_A, 7'h7f);
    write_reg(CFG_SPARE_B, 7'h01);
    queue_round(2, 0);
    drain();

    // random rounds, mostly small counts
    sent = 0;
    while (sent < RandomItems) begin
      sel = $urandom_range(0, 19);
      if (sent == 0) cnt_val = MaxParticles;
      else if (sel < 13) cnt_val = $urandom_range(2, 10);
      else if (sel < 16) cnt_val = $urandom_range(11, 40);
      else if (sel == 16) cnt_val = ($urandom_range(0, 1) == 0) ? MaxParticles : 127;
      else if (sel == 17) cnt_val = $urandom_range(0, 1);
      else if (sel == 18) cnt_val = $urandom_range(65, 126);
      else cnt_val = $urandom_range(2, 6);
      dims_val = ($urandom_range(0, 3) == 0) ? CfgDataW'($urandom) : CfgDataW'($urandom_range(0, 7));
      write_reg(CFG_PARTICLE_COUNT, CfgDataW'(cnt_val));
      write_reg(CFG_DIMS_IN_USE, dims_val);
      steady_send = ($urandom_range(0, 3) == 0);
      steady_recv = ($urandom_range(0, 3) == 0);
      n_eff = (cnt_val < 2) ? 2 : (cnt_val > MaxParticles) ? MaxParticles : cnt_val;
      rounds = (n_eff > 32) ? 1 : $urandom_range(1, 3);
      for (int unsigned i = 0; i < rounds; i++) begin
        queue_round(n_eff, $urandom_range(0, 5));
        sent += n_eff;
      end
      if ($urandom_range(0, 4) == 0) begin
        extra = $urandom_range(1, n_eff - 1);
        queue_round(extra, 0);
        sent += extra;
      end
      drain();
    end

    drain();
    if (mismatch_cnt == 0 && resampled_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/swr_pkg.sv
hw/rtl/swr_store.sv
hw/rtl/swr_mac.sv
hw/rtl/systematic_weight_resampler.sv
tb/systematic_weight_resampler_tb.sv
